>>> hw/rtl/spq_pkg.sv
// Shared types and codes for the stable priority ready queue.
// No dependencies; used by spq_cell and stable_priority_ready_queue.
package spq_pkg;

    localparam logic OP_SCHEDULE = 1'b0;
    localparam logic OP_TAKE     = 1'b1;

    typedef struct packed {
        logic ins;
        logic take;
    } t_cell_cmd;

endpackage

>>> hw/rtl/spq_cell.sv
// One cell of the sorted shift-register queue: holds one entry.
// Depends on spq_pkg for the command struct.
module spq_cell #(
    parameter int ID_W   = 4,
    parameter int PRIO_W = 8
) (
    input  logic               i_clk,
    input  spq_pkg::t_cell_cmd i_cmd,
    input  logic               i_occupied,
    input  logic               i_prev_lower,
    input  logic [ID_W-1:0]    i_new_obj,
    input  logic [PRIO_W-1:0]  i_new_prio,
    input  logic [ID_W-1:0]    i_prev_obj,
    input  logic [PRIO_W-1:0]  i_prev_prio,
    input  logic [ID_W-1:0]    i_next_obj,
    input  logic [PRIO_W-1:0]  i_next_prio,
    output logic               o_lower,
    output logic [ID_W-1:0]    o_obj,
    output logic [PRIO_W-1:0]  o_prio
);

    logic [ID_W-1:0]   r_obj;
    logic [PRIO_W-1:0] r_prio;
    logic [ID_W-1:0]   n_obj;
    logic [PRIO_W-1:0] n_prio;

    // A cell is a place for the new entry once it is empty or holds a strictly lower priority.
    assign o_lower = !i_occupied || (r_prio < i_new_prio);

    always_comb begin
        n_obj  = r_obj;
        n_prio = r_prio;
        if (i_cmd.ins && o_lower) begin
            if (i_prev_lower) begin
                n_obj  = i_prev_obj;
                n_prio = i_prev_prio;
            end else begin
                n_obj  = i_new_obj;
                n_prio = i_new_prio;
            end
        end else if (i_cmd.take) begin
            n_obj  = i_next_obj;
            n_prio = i_next_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_obj  <= n_obj;
        r_prio <= n_prio;
    end

    assign o_obj  = r_obj;
    assign o_prio = r_prio;

endmodule

>>> hw/rtl/stable_priority_ready_queue.sv
// Top level of the stable priority ready queue: a chain of spq_cell entries,
// the entry count and the result register. Depends on spq_pkg and spq_cell.
//
//  channel | direction | handshake          | fields
//  input   | in        | i_valid / o_stall  | opcode, object_id, priority_req
//  result  | out       | o_valid / i_stall  | accepted, taken_valid, taken_object,
//          |           |                    | pending_count
//
// One item is accepted per cycle; its result appears in the next cycle.
// Every cell compares its priority with the new one in parallel, so the insert
// or the shift toward the head finishes in the accepting cycle.
// Reset clears the entry count and the result valid; entry storage is not reset.
// While a result waits under stall, no new item is accepted.
module stable_priority_ready_queue #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int OBJECT_COUNT  = 16,
    parameter int PRIORITY_BITS = 8,
    localparam int ID_W  = $clog2(OBJECT_COUNT),
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_opcode,
    input  logic [ID_W-1:0]          i_object_id,
    input  logic [PRIORITY_BITS-1:0] i_priority_req,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_accepted,
    output logic                     o_taken_valid,
    output logic [ID_W-1:0]          o_taken_object,
    output logic [CNT_W-1:0]         o_pending_count
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    logic             r_acc;
    logic             r_tv;
    logic [ID_W-1:0]  r_tobj;
    logic [CNT_W-1:0] r_cnt;

    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    spq_pkg::t_cell_cmd w_cmd;

    logic [ID_W-1:0]          w_obj   [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] w_prio  [QUEUE_DEPTH];
    logic                     w_lower [QUEUE_DEPTH];

    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;
    assign w_full   = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty  = (r_count == '0);

    assign w_cmd.ins  = w_accept && (i_opcode == spq_pkg::OP_SCHEDULE) && !w_full;
    assign w_cmd.take = w_accept && (i_opcode == spq_pkg::OP_TAKE) && !w_empty;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic                     w_prev_lower;
            logic [ID_W-1:0]          w_prev_obj;
            logic [PRIORITY_BITS-1:0] w_prev_prio;
            logic [ID_W-1:0]          w_next_obj;
            logic [PRIORITY_BITS-1:0] w_next_prio;

            if (g == 0) begin : g_head
                assign w_prev_lower = 1'b0;
                assign w_prev_obj   = i_object_id;
                assign w_prev_prio  = i_priority_req;
            end else begin : g_body
                assign w_prev_lower = w_lower[g-1];
                assign w_prev_obj   = w_obj[g-1];
                assign w_prev_prio  = w_prio[g-1];
            end

            if (g == QUEUE_DEPTH - 1) begin : g_tail
                assign w_next_obj  = w_obj[g];
                assign w_next_prio = w_prio[g];
            end else begin : g_mid
                assign w_next_obj  = w_obj[g+1];
                assign w_next_prio = w_prio[g+1];
            end

            spq_cell #(
                .ID_W   (ID_W),
                .PRIO_W (PRIORITY_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_cmd        (w_cmd),
                .i_occupied   (CNT_W'(g) < r_count),
                .i_prev_lower (w_prev_lower),
                .i_new_obj    (i_object_id),
                .i_new_prio   (i_priority_req),
                .i_prev_obj   (w_prev_obj),
                .i_prev_prio  (w_prev_prio),
                .i_next_obj   (w_next_obj),
                .i_next_prio  (w_next_prio),
                .o_lower      (w_lower[g]),
                .o_obj        (w_obj[g]),
                .o_prio       (w_prio[g])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (w_cmd.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_cmd.take) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_acc  <= w_cmd.ins;
            r_tv   <= w_cmd.take;
            r_tobj <= w_cmd.take ? w_obj[0] : '0;
            r_cnt  <= n_count;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_accepted      = r_acc;
    assign o_taken_valid   = r_tv;
    assign o_taken_object  = r_tobj;
    assign o_pending_count = r_cnt;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_accepted && o_taken_valid))
        else $error("result both stored and took an entry");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ins |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("stored item did not raise the count");

    a_result_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_valid && o_pending_count == r_count)
        else $error("reported count differs from stored count");

endmodule

>>> tb/tb_stable_priority_ready_queue.sv
// Self-checking testbench for stable_priority_ready_queue: random and directed schedule
// and take items are checked against an in-bench model of the sorted ready queue.
// Depends on spq_pkg and the stable_priority_ready_queue RTL.
module tb_stable_priority_ready_queue;

    localparam int DEPTH       = 16;
    localparam int IDLE_LIMIT  = 5000;
    localparam int PHASE_ITEMS = 150;

    typedef struct {
        logic       op;
        logic [3:0] obj;
        logic [7:0] prio;
        bit         drain;
    } t_sched_item;

    typedef struct packed {
        logic       accepted;
        logic       taken_valid;
        logic [3:0] taken_object;
        logic [4:0] pending_count;
    } t_ready_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       i_opcode = 1'b0;
    logic [3:0] i_object_id = '0;
    logic [7:0] i_priority_req = '0;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_accepted;
    logic       o_taken_valid;
    logic [3:0] o_taken_object;
    logic [4:0] o_pending_count;

    t_sched_item   pending_items_q[$];
    t_ready_result result_expect_q[$];

    logic [3:0] model_obj[DEPTH];
    logic [7:0] model_prio[DEPTH];
    int         model_count = 0;

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  in_fire = 0;
    bit  out_fire = 0;
    int  idle_cycles = 0;
    int  fail_count = 0;
    int  results_checked = 0;
    int  n_stored = 0;
    int  n_rejected = 0;
    int  n_taken = 0;
    int  n_empty_takes = 0;
    int  peak_count = 0;

    stable_priority_ready_queue uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_opcode        (i_opcode),
        .i_object_id     (i_object_id),
        .i_priority_req  (i_priority_req),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_accepted      (o_accepted),
        .o_taken_valid   (o_taken_valid),
        .o_taken_object  (o_taken_object),
        .o_pending_count (o_pending_count)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_ready_result predict_ready_queue(logic op, logic [3:0] obj,
                                                          logic [7:0] prio);
        t_ready_result r;
        int pos;
        r = '0;
        if (op == spq_pkg::OP_SCHEDULE) begin
            if (model_count < DEPTH) begin
                pos = model_count;
                for (int i = model_count - 1; i >= 0; i--) begin
                    if (model_prio[i] < prio) begin
                        pos = i;
                    end
                end
                for (int i = model_count; i > pos; i--) begin
                    model_obj[i]  = model_obj[i-1];
                    model_prio[i] = model_prio[i-1];
                end
                model_obj[pos]  = obj;
                model_prio[pos] = prio;
                model_count++;
                r.accepted = 1'b1;
            end
        end else begin
            if (model_count > 0) begin
                r.taken_valid  = 1'b1;
                r.taken_object = model_obj[0];
                for (int i = 1; i < model_count; i++) begin
                    model_obj[i-1]  = model_obj[i];
                    model_prio[i-1] = model_prio[i];
                end
                model_count--;
            end
        end
        r.pending_count = model_count[4:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("MISMATCH at result %0d: %s is %0d, expected %0d",
                 results_checked, field, got, want);
        fail_count++;
    endtask

    task automatic push_item(logic op, logic [3:0] obj, logic [7:0] prio, bit drain);
        t_sched_item it;
        it.op = op;
        it.obj = obj;
        it.prio = prio;
        it.drain = drain;
        pending_items_q.push_back(it);
    endtask

    task automatic push_random_phase(int count);
        int sched_pct;
        int burst;
        int sel;
        logic [7:0] prio;
        sched_pct = 50;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                sel = $urandom_range(2);
                sched_pct = (sel == 0) ? 15 : (sel == 1) ? 50 : 85;
                burst = $urandom_range(40, 10);
            end
            burst--;
            sel = $urandom_range(99);
            if (sel < 50) begin
                prio = 8'($urandom_range(3));
            end else if (sel < 60) begin
                prio = 8'd0;
            end else if (sel < 70) begin
                prio = 8'd255;
            end else begin
                prio = 8'($urandom_range(255));
            end
            push_item(($urandom_range(99) < sched_pct) ? spq_pkg::OP_SCHEDULE
                                                      : spq_pkg::OP_TAKE,
                      4'($urandom_range(15)), prio, 1'b0);
        end
    endtask

    always @(negedge i_clk) begin
        bit go;
        t_sched_item it;
        if (i_rst_n && (!i_valid || in_fire)) begin
            go = pending_items_q.size() > 0 && $urandom_range(99) >= send_idle_pct;
            if (go && pending_items_q[0].drain && result_expect_q.size() != 0) begin
                go = 0;
            end
            if (go) begin
                it = pending_items_q.pop_front();
                i_valid        <= 1'b1;
                i_opcode       <= it.op;
                i_object_id    <= it.obj;
                i_priority_req <= it.prio;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= $urandom_range(99) < recv_stall_pct;
    end

    always @(posedge i_clk) begin
        t_ready_result want;
        in_fire  = i_rst_n && i_valid && !o_stall;
        out_fire = i_rst_n && o_valid && !i_stall;
        if (in_fire) begin
            want = predict_ready_queue(i_opcode, i_object_id, i_priority_req);
            result_expect_q.push_back(want);
            if (i_opcode == spq_pkg::OP_SCHEDULE) begin
                if (want.accepted) n_stored++;
                else n_rejected++;
            end else begin
                if (want.taken_valid) n_taken++;
                else n_empty_takes++;
            end
            if (model_count > peak_count) peak_count = model_count;
        end
        if (out_fire) begin
            if (result_expect_q.size() == 0) begin
                report_mismatch("result without item outstanding", 1, 0);
            end else begin
                want = result_expect_q.pop_front();
                if (o_accepted !== want.accepted)
                    report_mismatch("accepted", o_accepted, want.accepted);
                if (o_taken_valid !== want.taken_valid)
                    report_mismatch("taken_valid", o_taken_valid, want.taken_valid);
                if (o_taken_object !== want.taken_object)
                    report_mismatch("taken_object", o_taken_object, want.taken_object);
                if (o_pending_count !== want.pending_count)
                    report_mismatch("pending_count", o_pending_count, want.pending_count);
            end
            results_checked++;
        end
        if (!i_rst_n || in_fire || out_fire) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        logic [3:0] fill_obj[16];
        logic [7:0] fill_prio[16];
        fill_obj  = '{4'd0, 4'd15, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
                      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd1};
        fill_prio = '{8'd10, 8'd10, 8'd255, 8'd0, 8'd10, 8'd255, 8'd128, 8'd0,
                      8'd1, 8'd254, 8'd10, 8'd128, 8'd255, 8'd0, 8'd7, 8'd10};
        send_idle_pct  = 37;
        recv_stall_pct = 45;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_item(spq_pkg::OP_TAKE, 4'd15, 8'd255, 1'b0);
        for (int i = 0; i < 16; i++) begin
            push_item(spq_pkg::OP_SCHEDULE, fill_obj[i], fill_prio[i], 1'b0);
        end
        push_item(spq_pkg::OP_SCHEDULE, 4'd9, 8'd255, 1'b0);
        push_item(spq_pkg::OP_TAKE, 4'd0, 8'd0, 1'b1);
        for (int i = 0; i < 4; i++) begin
            push_item(spq_pkg::OP_TAKE, 4'($urandom_range(15)), 8'($urandom_range(255)),
                      1'b0);
        end
        push_random_phase(PHASE_ITEMS);
        while (pending_items_q.size() != 0) @(posedge i_clk);

        send_idle_pct  = 45;
        recv_stall_pct = 37;
        push_item(spq_pkg::OP_TAKE, 4'd0, 8'd0, 1'b1);
        push_random_phase(PHASE_ITEMS);
        while (pending_items_q.size() != 0) @(posedge i_clk);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        push_random_phase(PHASE_ITEMS);
        while (pending_items_q.size() != 0 || i_valid) @(posedge i_clk);
        while (result_expect_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Covered %0d stored and %0d rejected schedules,", n_stored, n_rejected);
        $display("%0d takes and %0d empty takes; checked %0d results, up to %0d entries held.",
                 n_taken, n_empty_takes, results_checked, peak_count);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
